[design/cths_pkg.sv]
package cths_pkg;

	localparam int unsigned RowWords = 256;

	localparam logic [31:0] LcgStart = 32'h0010_0001;
	localparam logic [31:0] LcgMul   = 32'd125;
	localparam logic [31:0] LcgAdd   = 32'd3;
	localparam logic [31:0] LcgMod   = 32'h002A_AAAB;

	localparam logic [31:0] MixAInit = 32'h7FED_7FED;
	localparam logic [31:0] MixBInit = 32'hEEEE_EEEE;

	localparam int unsigned RowSelW = 3;

	typedef logic [RowSelW-1:0] row_sel_t;
	typedef logic [31:0]        hash_t;

	// next seed of the table generator, used at elaboration only
	function automatic logic [31:0] lcg_next(input logic [31:0] s);
		return (s * LcgMul + LcgAdd) % LcgMod;
	endfunction

endpackage

[design/crypt_table_string_hash.sv]
// channel   | direction | payload
// s_axis    | in        | tdata[7:0] character, tlast last_char, tuser empty_name
// m_axis    | out       | tdata[31:0] hash_value
// cfg       | in        | data[2:0] table_row
//
// one character per cycle unless stalled; s1 registers it, hash_q the result
// the rom word is read into s1, then mixed from s1 into the running seeds
// reset loads the start seeds and table_row = 1; the rom is constant, no clearing pass
// a held result stalls a last or empty transaction in s1 and all input behind it
module crypt_table_string_hash #(
	parameter int unsigned TABLE_ROWS = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] character
	input  logic                 s_axis_tlast,
	input  logic                 s_axis_tuser,  // [0] empty_name

	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output cths_pkg::hash_t      m_axis_tdata,  // [31:0] hash_value

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  cths_pkg::row_sel_t   cfg_data
);
	import cths_pkg::*;

	localparam int unsigned TableWords = TABLE_ROWS * RowWords;
	localparam int unsigned AddrW      = $clog2(TableWords);

	typedef logic [31:0]        rom_t  [TableWords];
	typedef logic [RowSelW-1:0] wrap_t [16];

	function automatic rom_t build_rom();
		rom_t        r;
		logic [31:0] s;
		logic [31:0] hi;
		s = LcgStart;
		for (int unsigned i = 0; i < RowWords; i++) begin
			for (int unsigned j = 0; j < TABLE_ROWS; j++) begin
				s  = lcg_next(s);
				hi = {s[15:0], 16'h0000};
				s  = lcg_next(s);
				r[i + RowWords * j] = hi | {16'h0000, s[15:0]};
			end
		end
		return r;
	endfunction

	// wrapped row for {table_row, character sign}
	function automatic wrap_t build_wrap();
		wrap_t r;
		int    h;
		for (int k = 0; k < 16; k++) begin
			h = (k >> 1) - (k & 1);
			if (h < 0) begin
				h = h + int'(TABLE_ROWS);
			end
			for (int n = 0; n < 8; n++) begin
				if (h >= int'(TABLE_ROWS)) begin
					h = h - int'(TABLE_ROWS);
				end
			end
			r[k] = RowSelW'(h);
		end
		return r;
	endfunction

	localparam rom_t  CryptRom = build_rom();
	localparam wrap_t WrapLut  = build_wrap();

	row_sel_t         table_row_q;
	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;
	logic             empty_s1;
	logic [31:0]      word_s1;
	logic [31:0]      mix_a_q;
	logic [31:0]      mix_b_q;
	logic             out_valid_q;
	hash_t            hash_q;

	logic             s_fire;
	logic             s1_result;
	logic             s1_advance;
	logic             s1_fire;
	row_sel_t         wrap_row;
	logic [AddrW-1:0] rom_addr;
	logic [31:0]      mix_sum;
	logic [31:0]      mix_a_new;
	logic [31:0]      mix_b_new;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_row_q <= RowSelW'(1);
		end else if (cfg_valid && cfg_ready) begin
			table_row_q <= cfg_data;
		end
	end

	// rom address
	assign wrap_row = WrapLut[{table_row_q, s_axis_tdata[7]}];
	assign rom_addr = AddrW'({wrap_row, s_axis_tdata});

	assign s1_result  = valid_s1 && (last_s1 || empty_s1);
	assign s1_advance = !s1_result || !out_valid_q || m_axis_tready;
	assign s1_fire    = valid_s1 && s1_advance;
	assign s_axis_tready = !valid_s1 || s1_advance;
	assign s_fire     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			char_s1  <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
			empty_s1 <= s_axis_tuser;
			word_s1  <= CryptRom[rom_addr];
		end
	end

	// seed mixing
	assign mix_sum   = mix_a_q + mix_b_q;
	assign mix_a_new = word_s1 ^ mix_sum;
	assign mix_b_new = {{24{char_s1[7]}}, char_s1} + mix_a_new + mix_b_q
		+ {mix_b_q[26:0], 5'b00000} + 32'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_a_q <= MixAInit;
			mix_b_q <= MixBInit;
		end else if (s1_fire) begin
			if (last_s1 || empty_s1) begin
				mix_a_q <= MixAInit;
				mix_b_q <= MixBInit;
			end else begin
				mix_a_q <= mix_a_new;
				mix_b_q <= mix_b_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_result) begin
			hash_q <= empty_s1 ? MixAInit : mix_a_new;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = hash_q;

	a_seeds_reload: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && s1_result |=> mix_a_q == MixAInit && mix_b_q == MixBInit)
		else $error("seeds not reloaded after a name");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && empty_s1 |=> m_axis_tvalid && m_axis_tdata == MixAInit)
		else $error("empty name gave a wrong hash");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s1_fire && s1_result))
		else $error("result without a finishing transaction");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> s1_result && out_valid_q && !m_axis_tready)
		else $error("input stalled without a held result");

endmodule
